// ----- design/vlt_pkg.sv -----
// Package for the voxel line traversal core: field widths, limits and
// the transaction and job structures shared by every module.
// No dependencies.
package vlt_pkg;

   // Voxel index width per axis
   localparam int COORD_BITS  = 10;
   localparam int NUM_AXES    = 3;
   // Longest Manhattan span that is walked; longer lines give one flagged result
   localparam int MAX_SPAN    = 63;
   localparam int MAG_BITS    = $clog2(MAX_SPAN + 1);
   localparam int SPAN_BITS   = COORD_BITS + 2;
   localparam int PROD_BITS   = 2 * MAG_BITS;
   // Crossing times stay below 3 * 21^3, so 16 bits never wrap
   localparam int ACC_BITS    = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
   } req_type;

   typedef struct packed {
      coord_type cell_x;
      coord_type cell_y;
      coord_type cell_z;
      logic      last_cell;
      logic      span_too_long;
   } rsp_type;

   // One classified line, as handed from the front end to the walker
   typedef struct packed {
      logic [NUM_AXES-1:0][COORD_BITS-1:0] start;
      logic [NUM_AXES-1:0][COORD_BITS-1:0] target;
      logic [NUM_AXES-1:0]                 active;
      logic [NUM_AXES-1:0]                 down;
      logic [NUM_AXES-1:0][PROD_BITS-1:0]  first_cross;
      logic                                too_long;
   } job_type;

   // Queue status seen by both ends
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// ----- design/voxel_line_traversal_core.sv -----
// Top level of the voxel line traversal core: front end, job queue and walker.
// Depends on vlt_pkg, vlt_front, vlt_queue and vlt_walker.
//
//   channel | ports                            | carries
//   --------+----------------------------------+--------------------------------
//   request | req_valid, req_stall, req_data   | start and end voxel of one line
//   result  | rsp_valid, rsp_stall, rsp_data   | one visited voxel, last/overlong
//
// The walker emits one voxel per cycle while rsp_stall does not hold it, so a
// line of Manhattan span S gives at most S + 1 results, fewer where axes step
// together; an overlong line gives a single result.
// After the request is taken, the job is first written into the queue and
// is then loaded into the result register once the walker is free.
// Lines follow back to back.
// Reset clears the queue, the walker and the result valid.
// req_stall rises only while the two-entry job queue is full; rsp_stall holds
// the walker in place.
module voxel_line_traversal_core
   import vlt_pkg::*;
#(
   parameter int SPAN_LIMIT = MAX_SPAN
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   qstat_type q_stat;
   logic      push;
   job_type   push_job;
   logic      pop;
   job_type   pop_job;

   vlt_front #(
      .SPAN_LIMIT (SPAN_LIMIT)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_job  (push_job)
   );

   vlt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_stat   (q_stat)
   );

   vlt_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .pop_job   (pop_job),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/vlt_front.sv -----
// Front end of the voxel line traversal core: accepts line transactions,
// works out direction, span and the first crossing time of each axis.
// Depends on vlt_pkg.
module vlt_front
   import vlt_pkg::*;
#(
   parameter int SPAN_LIMIT = MAX_SPAN
)
(
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  qstat_type q_stat,
   output logic      push,
   output job_type   push_job
);

   logic [NUM_AXES-1:0][COORD_BITS-1:0] s_c;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] t_c;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] mag;
   logic [NUM_AXES-1:0][MAG_BITS-1:0]   opnd;
   logic [SPAN_BITS-1:0]                span;

   // Hold off the requester while the queue is full
   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      s_c = {req_data.start_z, req_data.start_y, req_data.start_x};
      t_c = {req_data.end_z, req_data.end_y, req_data.end_x};
      span = '0;
      // Direction and distance per axis
      for (int i = 0; i < NUM_AXES; i++) begin
         push_job.active[i] = (t_c[i] != s_c[i]);
         push_job.down[i]   = (t_c[i] < s_c[i]);
         mag[i] = push_job.down[i] ? (s_c[i] - t_c[i]) : (t_c[i] - s_c[i]);
         span   = span + SPAN_BITS'(mag[i]);
         // An idle axis counts as one in the product of spans
         opnd[i] = push_job.active[i] ? mag[i][MAG_BITS-1:0] : MAG_BITS'(1);
      end
      push_job.start    = s_c;
      push_job.target   = t_c;
      push_job.too_long = (span > SPAN_BITS'(SPAN_LIMIT));
      // First crossing of axis a sits at P / m_a: the product of the other spans
      push_job.first_cross[0] = PROD_BITS'(opnd[1] * opnd[2]);
      push_job.first_cross[1] = PROD_BITS'(opnd[0] * opnd[2]);
      push_job.first_cross[2] = PROD_BITS'(opnd[0] * opnd[1]);
   end

endmodule

// ----- design/vlt_queue.sv -----
// Short job queue between the front end and the walker.
// Depends on vlt_pkg.
module vlt_queue
   import vlt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   input  logic      pop,
   output job_type   pop_job,
   output qstat_type q_stat
);

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_job      = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- design/vlt_walker.sv -----
// Back end of the voxel line traversal core: steps a line one voxel per
// cycle while the result is not stalled, with integer crossing accumulators,
// and drives the result register. Depends on vlt_pkg.
module vlt_walker
   import vlt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  job_type   pop_job,
   input  qstat_type q_stat,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic                                busy_ff, busy_in;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] cur_ff, cur_in;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] tgt_ff, tgt_in;
   logic [NUM_AXES-1:0]                 active_ff, active_in;
   logic [NUM_AXES-1:0]                 down_ff, down_in;
   logic [NUM_AXES-1:0][ACC_BITS-1:0]   acc_ff, acc_in;
   logic [NUM_AXES-1:0][ACC_BITS-1:0]   inc_ff, inc_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   rsp_type                             rsp_data_ff, rsp_data_in;

   logic                                out_free;
   logic [NUM_AXES-1:0]                 eligible;
   logic [NUM_AXES-1:0]                 step_mask;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] nxt_cur;
   logic                                nxt_at;
   logic                                is_min;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = out_free && !busy_ff && !q_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Pick the axes whose next crossing is the earliest; ties step together
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         eligible[i] = active_ff[i] && (cur_ff[i] != tgt_ff[i]);
      end
      for (int i = 0; i < NUM_AXES; i++) begin
         is_min = 1'b1;
         for (int j = 0; j < NUM_AXES; j++) begin
            if (j != i && eligible[j] && (acc_ff[j] < acc_ff[i])) begin
               is_min = 1'b0;
            end
         end
         step_mask[i] = eligible[i] && is_min;
         if (!step_mask[i]) begin
            nxt_cur[i] = cur_ff[i];
         end else if (down_ff[i]) begin
            nxt_cur[i] = cur_ff[i] - COORD_BITS'(1);
         end else begin
            nxt_cur[i] = cur_ff[i] + COORD_BITS'(1);
         end
      end
      nxt_at = (nxt_cur == tgt_ff);
   end

   // Load a new line, advance the current one, or hold while stalled
   always_comb begin
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      active_in    = active_ff;
      down_in      = down_ff;
      acc_in       = acc_ff;
      inc_in       = inc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
         if (busy_ff) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               if (step_mask[i]) begin
                  acc_in[i] = acc_ff[i] + inc_ff[i];
               end
            end
            cur_in                    = nxt_cur;
            busy_in                   = !nxt_at;
            rsp_valid_in              = 1'b1;
            rsp_data_in.cell_x        = nxt_cur[0];
            rsp_data_in.cell_y        = nxt_cur[1];
            rsp_data_in.cell_z        = nxt_cur[2];
            rsp_data_in.last_cell     = nxt_at;
            rsp_data_in.span_too_long = 1'b0;
         end else if (!q_stat.empty) begin
            rsp_valid_in = 1'b1;
            if (pop_job.too_long) begin
               // Overlong line: one flagged result at the origin
               busy_in                   = 1'b0;
               rsp_data_in.cell_x        = '0;
               rsp_data_in.cell_y        = '0;
               rsp_data_in.cell_z        = '0;
               rsp_data_in.last_cell     = 1'b1;
               rsp_data_in.span_too_long = 1'b1;
            end else begin
               for (int i = 0; i < NUM_AXES; i++) begin
                  acc_in[i] = ACC_BITS'(pop_job.first_cross[i]);
                  inc_in[i] = ACC_BITS'({pop_job.first_cross[i], 1'b0});
               end
               cur_in                    = pop_job.start;
               tgt_in                    = pop_job.target;
               active_in                 = pop_job.active;
               down_in                   = pop_job.down;
               busy_in                   = (pop_job.start != pop_job.target);
               rsp_data_in.cell_x        = pop_job.start[0];
               rsp_data_in.cell_y        = pop_job.start[1];
               rsp_data_in.cell_z        = pop_job.start[2];
               rsp_data_in.last_cell     = (pop_job.start == pop_job.target);
               rsp_data_in.span_too_long = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      tgt_ff      <= tgt_in;
      active_ff   <= active_in;
      down_ff     <= down_in;
      acc_ff      <= acc_in;
      inc_ff      <= inc_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A line in progress has not yet reached its end voxel
   a_busy_not_at_end: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_ff != tgt_ff))
      else $error("walker busy at its end voxel");

   // A line in progress always has an axis to step
   a_busy_steps: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_mask != '0))
      else $error("walker busy with no axis to step");

   // A flagged result is the single last result at the origin
   a_too_long_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.span_too_long) |->
         (rsp_data_ff.last_cell && rsp_data_ff.cell_x == '0 &&
          rsp_data_ff.cell_y == '0 && rsp_data_ff.cell_z == '0))
      else $error("malformed overlong result");

   // A stalled result freezes the walk
   a_stall_holds_walk: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !out_free) |=> (busy_ff && $stable(cur_ff) && $stable(acc_ff)))
      else $error("walk advanced under stall");
`endif

endmodule
